// ===== rtl/alse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alse_pkg
// Shared types, codes and the nibble pattern table of the LED SPI encoder.
// ----------------------------------------------------------------------------
package alse_pkg;

    localparam int CNT_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 6;
    localparam int WORD_W   = 16;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int PIX_WORDS = 6;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_EOF   = 1'b1;

    localparam logic LED_SHORT = 1'b0;
    localparam logic LED_LONG  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LED_TYPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_SHORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LONG  = 2'd2;

    localparam logic [CNT_W-1:0] RESET_SHORT_INIT = 6'd10;
    localparam logic [CNT_W-1:0] RESET_LONG_INIT  = 6'd56;

    typedef struct packed {
        logic             lead;
        logic             kind;
        logic [23:0]      bytes;
        logic [CNT_W-1:0] count;
    } t_cmd;

    // Each LED bit becomes one hex digit: 7 for a one, 1 for a zero, bit 0 first.
    function automatic logic [WORD_W-1:0] nibble_pattern(input logic [3:0] nib);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < 4; i++) begin
            w[WORD_W-1-4*i -: 4] = nib[i] ? 4'h7 : 4'h1;
        end
        return w;
    endfunction

endpackage

// ===== rtl/alse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alse_pixel_if / alse_word_if
// Valid/ready channels for pixel items and SPI words.
// ----------------------------------------------------------------------------
interface alse_pixel_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, kind, red, green, blue, input ready);
    modport sink   (input valid, kind, red, green, blue, output ready);
endinterface

interface alse_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] spi_word;
    logic        last_of_run;
    logic        frame_done;

    modport source (output valid, spi_word, last_of_run, frame_done, input ready);
    modport sink   (input valid, spi_word, last_of_run, frame_done, output ready);
endinterface

// ===== rtl/alse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alse_front
// Accepts items, holds configuration and frame state, builds word commands.
// ----------------------------------------------------------------------------
module alse_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [alse_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [alse_pkg::CFG_W-1:0]      i_cfg_data,
    alse_pixel_if.sink                      i_pix,
    input  logic                            i_q_full,
    output logic                            o_push,
    output alse_pkg::t_cmd                  o_cmd
);
    import alse_pkg::*;

    logic             r_led_type;
    logic [CNT_W-1:0] r_reset_short;
    logic [CNT_W-1:0] r_reset_long;
    logic             r_frame_open;
    logic [CNT_W-1:0] sel_count;

    assign i_pix.ready = !i_q_full;
    assign o_push      = i_pix.valid && !i_q_full;

    assign sel_count = (r_led_type == LED_LONG) ? r_reset_long : r_reset_short;

    always_comb begin
        o_cmd.lead  = !r_frame_open;
        o_cmd.kind  = i_pix.kind;
        o_cmd.bytes = (r_led_type == LED_LONG) ? {i_pix.red, i_pix.green, i_pix.blue}
                                               : {i_pix.green, i_pix.red, i_pix.blue};
        // a zero count still sends one flagged word
        o_cmd.count = (sel_count == '0) ? CNT_W'(1) : sel_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_type    <= LED_SHORT;
            r_reset_short <= RESET_SHORT_INIT;
            r_reset_long  <= RESET_LONG_INIT;
            r_frame_open  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LED_TYPE:    r_led_type    <= i_cfg_data[0];
                    CFG_RESET_SHORT: r_reset_short <= i_cfg_data[CNT_W-1:0];
                    CFG_RESET_LONG:  r_reset_long  <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (o_push) begin
                r_frame_open <= (i_pix.kind == KIND_PIXEL);
            end
        end
    end

endmodule

// ===== rtl/alse_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alse_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module alse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  alse_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output alse_pkg::t_cmd o_head
);
    import alse_pkg::*;

    localparam int CW = $clog2(QDEPTH + 1);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_full  = (r_count == CW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue pop while empty");

endmodule

// ===== rtl/alse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alse_back
// Head command to output register: one SPI word per cycle unless o_word stalls.
// ----------------------------------------------------------------------------
module alse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  alse_pkg::t_cmd i_head,
    output logic           o_pop,
    alse_word_if.source    o_word
);
    import alse_pkg::*;

    logic [CNT_W-1:0]  r_step;
    logic              r_lead_done;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_last;
    logic              r_done;

    logic              emit_lead;
    logic              last;
    logic              load;
    logic [3:0]        nib;
    logic [WORD_W-1:0] word;

    always_comb begin
        case (r_step[2:0])
            3'd0:    nib = i_head.bytes[23:20];
            3'd1:    nib = i_head.bytes[19:16];
            3'd2:    nib = i_head.bytes[15:12];
            3'd3:    nib = i_head.bytes[11:8];
            3'd4:    nib = i_head.bytes[7:4];
            3'd5:    nib = i_head.bytes[3:0];
            default: nib = 4'h0;
        endcase
    end

    assign emit_lead = i_head.lead && !r_lead_done;
    assign last      = !emit_lead &&
                       ((i_head.kind == KIND_PIXEL) ? (r_step == CNT_W'(PIX_WORDS - 1))
                                                    : (r_step == i_head.count - 1'b1));
    assign word      = (emit_lead || i_head.kind == KIND_EOF) ? '0 : nibble_pattern(nib);
    assign load      = i_valid && (!r_out_valid || o_word.ready);
    assign o_pop     = load && last;

    assign o_word.valid       = r_out_valid;
    assign o_word.spi_word    = r_word;
    assign o_word.last_of_run = r_last;
    assign o_word.frame_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= word;
            r_last <= last;
            r_done <= last && (i_head.kind == KIND_EOF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_lead_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                if (emit_lead) begin
                    r_lead_done <= 1'b1;
                end else if (last) begin
                    r_step      <= '0;
                    r_lead_done <= 1'b0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end else if (o_word.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done |-> r_last) else $error("frame_done without last_of_run");
    a_pixel_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_head.kind == KIND_PIXEL |-> r_step < CNT_W'(PIX_WORDS))
        else $error("pixel step out of range");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_word.ready |=> r_out_valid && $stable(r_word))
        else $error("output word changed while stalled");

endmodule

// ===== rtl/addressable_led_spi_encoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_spi_encoder_unit
// Pixel stream to 16-bit SPI words for one-wire addressable LEDs.
//
// i_pix carries pixels (kind 0) and end-of-frame marks (kind 1); o_word
// carries SPI words, one transfer per word. A pixel gives six pattern words,
// seven when it opens a frame (a zero lead-in word first). An end-of-frame
// mark gives the reset run of zero words, its last word flagged.
// A command passes through the queue and then the output register before its
// first word shows on o_word. Throughput: one word per cycle while o_word is
// ready, set by the output register. A two-entry command queue lets input
// transfers proceed while words are still being sent. Configuration is
// written through i_cfg_we/i_cfg_idx/i_cfg_data while idle: the user must
// keep to this, as the block itself does not enforce it.
// Reset: type 0, reset counts 10 and 56, no frame open, queue empty.
// When o_word stalls, the word holds and the queue fills, then i_pix.ready
// drops until the back moves on.
// ----------------------------------------------------------------------------
module addressable_led_spi_encoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [alse_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [alse_pkg::CFG_W-1:0]      i_cfg_data,
    alse_pixel_if.sink                      i_pix,
    alse_word_if.source                     o_word
);
    import alse_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_cmd cmd;
    t_cmd head;

    alse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    alse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    alse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (head),
        .o_pop   (pop),
        .o_word  (o_word)
    );

endmodule
